// File: rtl/faa_pkg.sv
// ----------------------------------------------------------------------------
// faa_pkg
// Shared types and constants for the fault alarm annunciator.
// ----------------------------------------------------------------------------
`default_nettype none

package faa_pkg;

  localparam int unsigned FAULT_W = 32;
  localparam int unsigned TICK_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // alarm levels, ordered by priority
  typedef enum logic [1:0] {
    LVL_NORMAL  = 2'd0,
    LVL_WARN    = 2'd1,
    LVL_PROTECT = 2'd2,
    LVL_FATAL   = 2'd3
  } level_t;

  typedef enum logic [1:0] {
    COLOR_OFF   = 2'd0,
    COLOR_RED   = 2'd1,
    COLOR_GREEN = 2'd2
  } color_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FATAL_MASK   = 2'd0,
    CFG_PROTECT_MASK = 2'd1,
    CFG_WARN_MASK    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  // blink patterns: warn is 5 on / 5 off, protect is 1 on / 1 off
  localparam int unsigned WARN_BLINK_LEN = 10;
  localparam int unsigned WARN_BLINK_ON  = 5;

  // buzzer rhythms in ticks
  localparam int unsigned WARN_BEEP_ON   = 1;
  localparam int unsigned WARN_BEEP_OFF  = 19;
  localparam int unsigned PROT_BEEP_ON   = 2;
  localparam int unsigned PROT_BEEP_OFF  = 8;
  localparam int unsigned FATAL_BEEP_ON  = 1;

  // longest phase period, every other period divides it
  localparam int unsigned PHASE_LEN = WARN_BEEP_ON + WARN_BEEP_OFF;
  localparam int unsigned PHASE_W   = $clog2(PHASE_LEN);

endpackage

`default_nettype wire

// File: rtl/fault_alarm_annunciator_core.sv
// ----------------------------------------------------------------------------
// fault_alarm_annunciator_core
// Ranks each tick's fault bits into an alarm level and drives the LED and
// buzzer patterns from a wrapping 8-bit tick counter.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_fault_mask       | request in
//  out     | out_valid, out_stall, out_alarm_level,  | request out
//          | out_led_color, out_white_on, out_buzzer_on |
//  cfg     | cfg_we, cfg_index, cfg_wdata            | write only
//
//  one request per cycle while the output is not stalled; a request passes
//  through the input register, then the state and result registers.
//  the tick phase is kept in a mod-20 counter beside the tick counter, both
//  cleared together when the tick counter wraps.
//  rst_n clears state and all masks; a stalled output holds its request and
//  the input stalls only when both registers are full.
`default_nettype none

module fault_alarm_annunciator_core
  import faa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [FAULT_W-1:0]   in_fault_mask,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_alarm_level,
  output logic [1:0]                out_led_color,
  output logic                      out_white_on,
  output logic                      out_buzzer_on,

  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FAULT_W-1:0]   cfg_wdata
);

  logic [FAULT_W-1:0] fatal_mask_r, protect_mask_r, warn_mask_r;

  logic               s1_valid_r;
  logic [FAULT_W-1:0] s1_fault_r;
  logic               out_valid_r;

  level_t             level_r, level_nxt;
  color_t             color_r, color_nxt;
  logic               white_r, white_nxt;
  logic               blink_r, blink_nxt;
  logic               beep_r, beep_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;

  logic               s2_ready;
  logic               s1_ready;
  logic               s2_fire;
  logic [PHASE_W-1:0] phase10;
  logic               pat_bit;

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s2_fire  = s1_valid_r && s2_ready;
  assign in_stall = !s1_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fatal_mask_r   <= '0;
      protect_mask_r <= '0;
      warn_mask_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FATAL_MASK:   fatal_mask_r   <= cfg_wdata;
        CFG_PROTECT_MASK: protect_mask_r <= cfg_wdata;
        CFG_WARN_MASK:    warn_mask_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_fault_r <= in_fault_mask;
    end
  end

  // tick phase folded to the warn blink period
  assign phase10 = (phase_r >= PHASE_W'(WARN_BLINK_LEN)) ?
                   phase_r - PHASE_W'(WARN_BLINK_LEN) : phase_r;

  always_comb begin
    level_nxt = LVL_NORMAL;
    if ((s1_fault_r & fatal_mask_r) != '0) begin
      level_nxt = LVL_FATAL;
    end else if ((s1_fault_r & protect_mask_r) != '0) begin
      level_nxt = LVL_PROTECT;
    end else if ((s1_fault_r & warn_mask_r) != '0) begin
      level_nxt = LVL_WARN;
    end
  end

  always_comb begin
    color_nxt = color_r;
    white_nxt = white_r;
    blink_nxt = blink_r;
    beep_nxt  = 1'b0;
    pat_bit   = 1'b0;
    case (level_nxt)
      LVL_FATAL: begin
        color_nxt = COLOR_RED;
        white_nxt = 1'b1;
        blink_nxt = 1'b1;
        beep_nxt  = (tick_r[0] == 1'b0) ? 1'b1 : 1'b0;
      end
      LVL_PROTECT: begin
        pat_bit  = !tick_r[0];
        beep_nxt = (phase10 < PHASE_W'(PROT_BEEP_ON));
        if (pat_bit != blink_r) begin
          blink_nxt = pat_bit;
          color_nxt = COLOR_RED;
          white_nxt = pat_bit;
        end
      end
      LVL_WARN: begin
        pat_bit  = (phase10 < PHASE_W'(WARN_BLINK_ON));
        beep_nxt = (phase_r < PHASE_W'(WARN_BEEP_ON));
        if (pat_bit != blink_r) begin
          blink_nxt = pat_bit;
          color_nxt = COLOR_OFF;
          white_nxt = pat_bit;
        end
      end
      default: begin
        color_nxt = COLOR_GREEN;
        white_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    tick_nxt  = tick_r + TICK_W'(1);
    phase_nxt = phase_r + PHASE_W'(1);
    // phase restarts on the counter wrap as well as at its own period
    if (tick_nxt == '0 || phase_r == PHASE_W'(PHASE_LEN - 1)) begin
      phase_nxt = '0;
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      level_r     <= LVL_NORMAL;
      color_r     <= COLOR_OFF;
      white_r     <= 1'b0;
      blink_r     <= 1'b0;
      beep_r      <= 1'b0;
      tick_r      <= '0;
      phase_r     <= '0;
    end else begin
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s2_fire) begin
        level_r <= level_nxt;
        color_r <= color_nxt;
        white_r <= white_nxt;
        blink_r <= blink_nxt;
        beep_r  <= beep_nxt;
        tick_r  <= tick_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_alarm_level = level_r;
  assign out_led_color   = color_r;
  assign out_white_on    = white_r;
  assign out_buzzer_on   = beep_r;

  a_fatal_leds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && level_r == LVL_FATAL) |-> (color_r == COLOR_RED && white_r && blink_r))
    else $error("fatal level without steady red and white");

  a_normal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && level_r == LVL_NORMAL) |-> (color_r == COLOR_GREEN && !white_r && !beep_r))
    else $error("normal level with alarm outputs");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PHASE_W'(PHASE_LEN - 1))
    else $error("tick phase out of range");

  a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_r == '0) |-> (phase_r == '0))
    else $error("tick phase not aligned to counter wrap");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(tick_r))
    else $error("state advanced while result stalled");

endmodule

`default_nettype wire

// File: verif/fault_alarm_annunciator_core_tb.sv
// ----------------------------------------------------------------------------
// fault_alarm_annunciator_core_tb
// Self-checking bench: fault requests go in through a queue-fed driver, each
// accepted request is ranked by a request-level annunciator model, and every
// result is checked field by field. Mask settings change between phases.
// ----------------------------------------------------------------------------
module fault_alarm_annunciator_core_tb
  import faa_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  // blink and beep rhythms in ticks
  localparam int WARN_BLINK_PERIOD = 10;
  localparam int WARN_BLINK_LIT    = 5;
  localparam int PROT_BLINK_PERIOD = 2;
  localparam int WARN_BEEP_PERIOD  = 20;
  localparam int WARN_BEEP_LEN     = 1;
  localparam int PROT_BEEP_PERIOD  = 10;
  localparam int PROT_BEEP_LEN     = 2;
  localparam int FATAL_BEEP_PERIOD = 2;
  localparam int FATAL_BEEP_LEN    = 1;
  localparam int LONG_HOLD_CYCLES  = 60;

  typedef struct packed {
    level_t level;
    color_t color;
    logic   white;
    logic   buzz;
  } annunc_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FAULT_W-1:0]   in_fault_mask = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_alarm_level;
  logic [1:0]           out_led_color;
  logic                 out_white_on;
  logic                 out_buzzer_on;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FAULT_W-1:0]   cfg_wdata = '0;

  fault_alarm_annunciator_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_fault_mask  (in_fault_mask),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_alarm_level(out_alarm_level),
    .out_led_color  (out_led_color),
    .out_white_on   (out_white_on),
    .out_buzzer_on  (out_buzzer_on),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // model copy of the masks and the annunciator state
  logic [31:0] fatal_m, protect_m, warn_m;
  level_t      lvl;
  logic [7:0]  tick;
  logic        blink, beep, wht;
  color_t      col;

  logic [31:0] fault_q[$];
  annunc_t     alarm_q[$];

  int  pushed = 0;
  int  accepted = 0;
  int  results_seen = 0;
  int  errors = 0;
  int  cycle_count = 0;
  int  mask_writes = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  in_took = 1'b0;
  bit  calm = 1'b0;
  bit  long_hold_pending = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic annunc_t annunciate(input logic [31:0] faults);
    logic    bit_now;
    annunc_t r;
    if (|(faults & fatal_m)) lvl = LVL_FATAL;
    else if (|(faults & protect_m)) lvl = LVL_PROTECT;
    else if (|(faults & warn_m)) lvl = LVL_WARN;
    else lvl = LVL_NORMAL;

    case (lvl)
      LVL_FATAL: begin
        col = COLOR_RED;
        wht = 1'b1;
        blink = 1'b1;
      end
      LVL_NORMAL: begin
        col = COLOR_GREEN;
        wht = 1'b0;
      end
      default: begin
        if (lvl == LVL_PROTECT) bit_now = (tick % PROT_BLINK_PERIOD) == 0;
        else bit_now = (tick % WARN_BLINK_PERIOD) < WARN_BLINK_LIT;
        // color and white only move on a blink transition
        if (bit_now != blink) begin
          blink = bit_now;
          col = (lvl == LVL_PROTECT) ? COLOR_RED : COLOR_OFF;
          wht = bit_now;
        end
      end
    endcase

    case (lvl)
      LVL_WARN:    beep = (tick % WARN_BEEP_PERIOD) < WARN_BEEP_LEN;
      LVL_PROTECT: beep = (tick % PROT_BEEP_PERIOD) < PROT_BEEP_LEN;
      LVL_FATAL:   beep = (tick % FATAL_BEEP_PERIOD) < FATAL_BEEP_LEN;
      default:     beep = 1'b0;
    endcase

    r.level = lvl;
    r.color = col;
    r.white = wht;
    r.buzz  = beep;
    tick = tick + 8'd1;
    return r;
  endfunction

  // driver: one request per accepted handshake, random idle bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // stalled, request stays as is
    end else begin
      in_took = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (fault_q.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (fault_q.size() != 0) begin
        in_fault_mask <= fault_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_pending) begin
      long_hold_pending = 1'b0;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0 && !calm) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report(input annunc_t want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at result %0d: expected level %0d color %0d white %0b buzzer %0b,",
               results_seen, want.level, want.color, want.white, want.buzz,
               " got level %0d color %0d white %0b buzzer %0b",
               out_alarm_level, out_led_color, out_white_on, out_buzzer_on);
  endtask

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    annunc_t want;
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, alarm_q.size());
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      alarm_q.push_back(annunciate(in_fault_mask));
      accepted++;
      in_took = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (alarm_q.size() == 0) begin
        want = '0;
        if (errors < MAX_REPORTS) $display("result with no request outstanding");
        report(want);
      end else begin
        want = alarm_q.pop_front();
        if (out_alarm_level !== want.level || out_led_color !== want.color ||
            out_white_on !== want.white || out_buzzer_on !== want.buzz)
          report(want);
      end
      results_seen++;
    end
  end

  task automatic push_fault(input logic [31:0] f);
    fault_q.push_back(f);
    pushed++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FATAL_MASK:   fatal_m = v;
      CFG_PROTECT_MASK: protect_m = v;
      CFG_WARN_MASK:    warn_m = v;
      default: ;
    endcase
    mask_writes++;
  endtask

  task automatic set_masks(input logic [31:0] f, input logic [31:0] p, input logic [31:0] w);
    write_reg(CFG_FATAL_MASK, f);
    write_reg(CFG_PROTECT_MASK, p);
    write_reg(CFG_WARN_MASK, w);
  endtask

  // wait until every request has come back, then let the pipeline settle
  task automatic drain();
    while (results_seen != pushed) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // fault word aimed at a given level under the current masks
  function automatic logic [31:0] fault_for(input level_t want);
    logic [31:0] hit, quiet;
    case (want)
      LVL_FATAL: begin
        hit = fatal_m;
        quiet = '0;
      end
      LVL_PROTECT: begin
        hit = protect_m & ~fatal_m;
        quiet = fatal_m;
      end
      LVL_WARN: begin
        hit = warn_m & ~fatal_m & ~protect_m;
        quiet = fatal_m | protect_m;
      end
      default: begin
        hit = '0;
        quiet = fatal_m | protect_m | warn_m;
      end
    endcase
    return ($urandom & ~quiet) | (hit & (~hit + 32'd1)) | ($urandom & hit);
  endfunction

  // runs of one level let the blink and beep phases play out
  task automatic push_runs(input int n);
    level_t want;
    int     len;
    while (n > 0) begin
      want = level_t'($urandom_range(0, 3));
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 8);
      for (int k = 0; k < len && n > 0; k++) begin
        push_fault(($urandom_range(0, 9) == 0) ? $urandom : fault_for(want));
        n--;
      end
    end
  endtask

  initial begin
    fatal_m = '0;
    protect_m = '0;
    warn_m = '0;
    lvl = LVL_NORMAL;
    tick = '0;
    blink = 1'b0;
    beep = 1'b0;
    col = COLOR_OFF;
    wht = 1'b0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // masks still clear after reset: everything ranks normal
    push_fault(32'h0000_0000);
    push_fault(32'hFFFF_FFFF);
    push_fault(32'h0000_0001);
    push_fault(32'h8000_0000);
    drain();

    set_masks(32'h0000_00FF, 32'h0000_FF00, 32'hFFFF_0000);
    // unused index must not disturb any mask
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    push_fault(32'h0000_0000);
    push_fault(32'h0001_0000);
    push_fault(32'h8000_0000);
    push_fault(32'h0000_0100);
    push_fault(32'h0000_8000);
    push_fault(32'h0000_0001);
    push_fault(32'hFFFF_FFFF);
    push_fault(32'h0101_0100);
    push_fault(32'h0000_0000);
    for (int k = 0; k < 12; k++) push_fault(32'h0002_0000);
    for (int k = 0; k < 4; k++) push_fault(32'h0000_0200);
    drain();

    // receiver holds off while requests keep coming
    push_runs(500);
    repeat (30) @(posedge clk);
    long_hold_pending = 1'b1;
    drain();

    // overlapping masks, higher level wins
    set_masks(32'hF0F0_F0F0, 32'hFF00_FF00, 32'hFFFF_FFFF);
    push_runs(400);
    drain();

    set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_runs(200);
    drain();

    set_masks($urandom, $urandom & $urandom, $urandom);
    push_runs(400);
    drain();

    // last stretch runs without idling
    set_masks(32'h0000_0000, $urandom & $urandom, $urandom);
    @(posedge clk);
    calm = 1'b1;
    push_runs(400);
    drain();
    repeat (6) @(negedge clk);

    errors += alarm_q.size();
    $display("covered %0d fault requests and %0d results across %0d mask writes",
             accepted, results_seen, mask_writes);
    $display("levels from normal to fatal with overlapping, full and sparse masks, tick wraps included");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: fault_alarm_annunciator_core.f
rtl/faa_pkg.sv
rtl/fault_alarm_annunciator_core.sv
verif/fault_alarm_annunciator_core_tb.sv
